// File: rtl/core/rad_pkg.sv
// rad_pkg: shared types and constants of the rtmp aggregate deframer
// item and result structs, parser phases, result kinds and error codes
// no dependencies
`timescale 1ns / 1ps

package rad_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_TRAILER
    } phase_t;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_TRUNC_HEADER = 2'd0;
    localparam logic [1:0] ERR_SIZE_OVERRUN = 2'd1;
    localparam logic [1:0] ERR_NO_TRAILER   = 2'd2;

    // header byte positions
    localparam logic [3:0] FLD_TYPE         = 4'd0;
    localparam logic [3:0] FLD_SIZE_LAST    = 4'd3;
    localparam logic [3:0] FLD_TIME_LAST    = 4'd6;
    localparam logic [3:0] FLD_TIME_HIGH    = 4'd7;
    localparam logic [3:0] FLD_STREAM_FIRST = 4'd8;
    localparam logic [3:0] FLD_REBASE       = 4'd9;
    localparam logic [3:0] FLD_HEADER_LAST  = 4'd10;

    localparam logic [3:0]  TRAILER_LEN = 4'd4;
    localparam logic [23:0] TRAILER_MIN = 24'd4;

    localparam logic [7:0] TYPE_AUDIO = 8'd8;
    localparam logic [7:0] TYPE_VIDEO = 8'd9;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        message_start;
        logic [23:0] message_length;
        logic [31:0] message_timestamp;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sub_type;
        logic [23:0] sub_size;
        logic [30:0] sub_raw_time;
        logic [31:0] sub_time;
        logic [23:0] sub_stream;
        logic [7:0]  payload_byte;
        logic        last_byte;
        logic [1:0]  error_code;
    } result_t;

endpackage

// File: rtl/core/rad_msg_if.sv
// rad_msg_if: input channel of the deframer, one payload byte per item
// valid/ready handshake with message start, length and timestamp
// no dependencies
`timescale 1ns / 1ps

interface rad_msg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        message_start;
    logic [23:0] message_length;
    logic [31:0] message_timestamp;

    modport source (
        output valid,
        output data_byte,
        output message_start,
        output message_length,
        output message_timestamp,
        input  ready
    );

    modport sink (
        input  valid,
        input  data_byte,
        input  message_start,
        input  message_length,
        input  message_timestamp,
        output ready
    );
endinterface

// File: rtl/core/rad_res_if.sv
// rad_res_if: result channel of the deframer, header, payload or error items
// valid/ready handshake
// no dependencies
`timescale 1ns / 1ps

interface rad_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  sub_type;
    logic [23:0] sub_size;
    logic [30:0] sub_raw_time;
    logic [31:0] sub_time;
    logic [23:0] sub_stream;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [1:0]  error_code;

    modport source (
        output valid,
        output kind,
        output sub_type,
        output sub_size,
        output sub_raw_time,
        output sub_time,
        output sub_stream,
        output payload_byte,
        output last_byte,
        output error_code,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  sub_type,
        input  sub_size,
        input  sub_raw_time,
        input  sub_time,
        input  sub_stream,
        input  payload_byte,
        input  last_byte,
        input  error_code,
        output ready
    );
endinterface

// File: rtl/core/rad_parser.sv
// rad_parser: per-byte sub-message parser state machine of the deframer
// header assembly, counters, timestamp rebasing and result forming
// depends on rad_pkg
`timescale 1ns / 1ps

module rad_parser
    import rad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [7:0]  type_reg, type_next;
    logic [23:0] size_reg, size_next;
    logic [30:0] time_reg, time_next;
    logic [23:0] stream_reg, stream_next;
    logic [23:0] left_reg, left_next;
    logic [23:0] pay_left_reg, pay_left_next;
    logic [30:0] base_reg, base_next;
    logic        first_reg, first_next;
    logic        fwd_reg, fwd_next;
    logic [31:0] parent_reg, parent_next;
    logic [31:0] rebase_reg, rebase_next;

    // values after a message start is applied
    phase_t      cur_phase;
    logic [3:0]  cur_count;
    logic [23:0] cur_left;
    logic        cur_first;
    logic [23:0] rem;
    logic [23:0] trail_room;
    logic [30:0] time_full;
    logic [3:0]  trail_count;

    assign cur_left    = item.message_start ? item.message_length : left_reg;
    assign cur_count   = item.message_start ? FLD_TYPE : count_reg;
    assign cur_first   = item.message_start ? 1'b0 : first_reg;
    assign rem         = cur_left - 24'd1;
    assign trail_room  = rem - size_reg;
    assign time_full   = {item.data_byte[6:0], time_reg[23:0]};
    assign trail_count = cur_count + 4'd1;

    always_comb
    begin
        if (item.message_start)
        begin
            cur_phase = (item.message_length != 24'd0) ? PH_HEADER : PH_IDLE;
        end
        else
        begin
            cur_phase = phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            type_reg     <= '0;
            size_reg     <= '0;
            time_reg     <= '0;
            stream_reg   <= '0;
            left_reg     <= '0;
            pay_left_reg <= '0;
            base_reg     <= '0;
            first_reg    <= 1'b0;
            fwd_reg      <= 1'b0;
            parent_reg   <= '0;
            rebase_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            type_reg     <= type_next;
            size_reg     <= size_next;
            time_reg     <= time_next;
            stream_reg   <= stream_next;
            left_reg     <= left_next;
            pay_left_reg <= pay_left_next;
            base_reg     <= base_next;
            first_reg    <= first_next;
            fwd_reg      <= fwd_next;
            parent_reg   <= parent_next;
            rebase_reg   <= rebase_next;
        end
    end

    always_comb
    begin
        phase_next    = cur_phase;
        count_next    = cur_count;
        type_next     = type_reg;
        size_next     = size_reg;
        time_next     = time_reg;
        stream_next   = stream_reg;
        left_next     = cur_left;
        pay_left_next = pay_left_reg;
        base_next     = base_reg;
        first_next    = cur_first;
        fwd_next      = fwd_reg;
        parent_next   = item.message_start ? item.message_timestamp : parent_reg;
        rebase_next   = rebase_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (cur_phase == PH_IDLE || cur_left == 24'd0)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            left_next = rem;
            case (cur_phase)
                PH_HEADER:
                begin
                    if (cur_count == FLD_TYPE)
                    begin
                        type_next   = item.data_byte;
                        size_next   = '0;
                        time_next   = '0;
                        stream_next = '0;
                    end
                    else if (cur_count <= FLD_SIZE_LAST)
                    begin
                        size_next = {size_reg[15:0], item.data_byte};
                    end
                    else if (cur_count <= FLD_TIME_LAST)
                    begin
                        time_next = {7'd0, time_reg[15:0], item.data_byte};
                    end
                    else if (cur_count == FLD_TIME_HIGH)
                    begin
                        time_next = time_full;
                        if (!cur_first)
                        begin
                            base_next  = time_full;
                            first_next = 1'b1;
                        end
                    end
                    else
                    begin
                        stream_next = {stream_reg[15:0], item.data_byte};
                    end

                    // rebase in two adds while the stream id arrives
                    if (cur_count == FLD_STREAM_FIRST)
                    begin
                        rebase_next = {1'b0, time_reg} - {1'b0, base_reg};
                    end
                    else if (cur_count == FLD_REBASE)
                    begin
                        rebase_next = parent_reg + rebase_reg;
                    end

                    if (cur_count < FLD_HEADER_LAST)
                    begin
                        count_next = cur_count + 4'd1;
                        if (rem == 24'd0)
                        begin
                            phase_next     = PH_IDLE;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_TRUNC_HEADER;
                        end
                    end
                    else
                    begin
                        count_next = FLD_TYPE;
                        if (size_reg > rem)
                        begin
                            phase_next     = PH_IDLE;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_SIZE_OVERRUN;
                        end
                        else if (trail_room < TRAILER_MIN)
                        begin
                            phase_next     = PH_IDLE;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_NO_TRAILER;
                        end
                        else
                        begin
                            fwd_next      = (type_reg == TYPE_AUDIO) || (type_reg == TYPE_VIDEO);
                            pay_left_next = size_reg;
                            phase_next    = (size_reg != 24'd0) ? PH_PAYLOAD : PH_TRAILER;
                            if (fwd_next)
                            begin
                                res_valid        = 1'b1;
                                res.kind         = KIND_HEADER;
                                res.sub_type     = type_next;
                                res.sub_size     = size_next;
                                res.sub_raw_time = time_next;
                                res.sub_time     = rebase_next;
                                res.sub_stream   = stream_next;
                            end
                        end
                    end
                end

                PH_PAYLOAD:
                begin
                    if (fwd_reg)
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.sub_type     = type_reg;
                        res.sub_size     = size_reg;
                        res.sub_raw_time = time_reg;
                        res.sub_time     = rebase_reg;
                        res.sub_stream   = stream_reg;
                        res.payload_byte = item.data_byte;
                        res.last_byte    = (pay_left_reg == 24'd1);
                    end
                    pay_left_next = pay_left_reg - 24'd1;
                    if (pay_left_next == 24'd0)
                    begin
                        phase_next = PH_TRAILER;
                        count_next = FLD_TYPE;
                    end
                    if (rem == 24'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end

                PH_TRAILER:
                begin
                    count_next = trail_count;
                    if (trail_count >= TRAILER_LEN)
                    begin
                        count_next = FLD_TYPE;
                        phase_next = PH_HEADER;
                    end
                    if (rem == 24'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end

                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> count_reg <= FLD_HEADER_LAST)
        else $error("header byte position out of range");

    a_error_idles: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res_valid && res.kind == KIND_ERROR |=> phase_reg == PH_IDLE)
        else $error("parser not idle after an error item");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> pay_left_reg != 24'd0)
        else $error("payload phase with no payload bytes left");
`endif

endmodule

// File: rtl/core/rtmp_aggregate_deframer.sv
// rtmp_aggregate_deframer: top level, splits an aggregate message into sub-messages
// input register, parser state machine and result register
// depends on rad_pkg, rad_msg_if, rad_res_if, rad_parser
`timescale 1ns / 1ps

// takes the payload of an aggregate message one byte per item and gives one item
// per forwarded sub-message header (audio and video only), one per payload byte of
// those, or one error item on a truncated header, a size overrun or a missing
// trailer, after which the rest of the message is dropped. the block sustains one
// byte per clock while the result register is empty or being read: a byte is held
// in the input register, the parser updates its header and counter state on it and
// writes any result into the result register, from which it can be taken. the
// result register decouples the two sides, and a new byte is taken whenever the
// input register is empty or moves on in the same cycle. the rebased timestamp is
// built with two adds while the stream id bytes arrive, so no cycle carries more
// than one 32-bit add. no reset sweep is needed: the block is ready right after
// reset

module rtmp_aggregate_deframer
    import rad_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rad_msg_if.sink   msg,
    rad_res_if.source res
);

    // input register
    logic    in_valid_reg;
    item_t   in_item_reg;

    // result register
    logic    out_valid_reg;
    result_t out_res_reg;

    // parser outputs
    logic    step_valid;
    result_t step_res;
    logic    advance;

    // the parser consumes the held byte whenever its result has somewhere to go
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign msg.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (msg.ready)
        begin
            in_valid_reg <= msg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.ready && msg.valid)
        begin
            in_item_reg.data_byte         <= msg.data_byte;
            in_item_reg.message_start     <= msg.message_start;
            in_item_reg.message_length    <= msg.message_length;
            in_item_reg.message_timestamp <= msg.message_timestamp;
        end
    end

    rad_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .item      (in_item_reg),
        .res_valid (step_valid),
        .res       (step_res)
    );

    // a byte with no result still frees the result register if it was taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step_valid;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_valid)
        begin
            out_res_reg <= step_res;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_res_reg.kind;
    assign res.sub_type     = out_res_reg.sub_type;
    assign res.sub_size     = out_res_reg.sub_size;
    assign res.sub_raw_time = out_res_reg.sub_raw_time;
    assign res.sub_time     = out_res_reg.sub_time;
    assign res.sub_stream   = out_res_reg.sub_stream;
    assign res.payload_byte = out_res_reg.payload_byte;
    assign res.last_byte    = out_res_reg.last_byte;
    assign res.error_code   = out_res_reg.error_code;

`ifndef SYNTHESIS
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> msg.ready)
        else $error("input stalled while result register is empty");

    a_error_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.kind == KIND_ERROR |->
            out_res_reg.sub_size == 24'd0 && out_res_reg.sub_stream == 24'd0 &&
            out_res_reg.payload_byte == 8'd0 && !out_res_reg.last_byte)
        else $error("error item carries header or payload fields");

    a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.last_byte |-> out_res_reg.kind == KIND_PAYLOAD)
        else $error("last byte flag on a non-payload item");
`endif

endmodule

// File: test/tb_top.sv
// tb_top: self-checking testbench of the rtmp aggregate deframer
// drives aggregate messages byte by byte, predicts results and checks them in order
// depends on rad_pkg, rad_msg_if, rad_res_if and rtmp_aggregate_deframer
`timescale 1ns / 1ps

module tb_top;
    import rad_pkg::*;

    localparam int unsigned LIMIT_CYCLES     = 400000;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES    = 20;
    localparam int unsigned MAX_REPORTS      = 10;
    localparam int unsigned PHASE_BYTES      = 700;

    // tracks the deframer state and keeps the results it must still give
    class deframe_scoreboard;
        phase_t      phase;
        logic [3:0]  field_count;
        logic [7:0]  type_reg;
        logic [23:0] size_reg;
        logic [30:0] raw_time;
        logic [23:0] stream_reg;
        logic [23:0] bytes_left;
        logic [23:0] payload_left;
        logic [30:0] time_origin;
        logic        first_seen;
        logic        forwarding;
        logic [31:0] parent_time;
        result_t     awaited[$];
        int unsigned failures;

        function new();
            phase        = PH_IDLE;
            field_count  = '0;
            type_reg     = '0;
            size_reg     = '0;
            raw_time     = '0;
            stream_reg   = '0;
            bytes_left   = '0;
            payload_left = '0;
            time_origin  = '0;
            first_seen   = 1'b0;
            forwarding   = 1'b0;
            parent_time  = '0;
            failures     = 0;
        endfunction

        function result_t header_result(logic [1:0] kind, logic [7:0] data, logic last);
            result_t r;
            r              = '0;
            r.kind         = kind;
            r.sub_type     = type_reg;
            r.sub_size     = size_reg;
            r.sub_raw_time = raw_time;
            // parent plus the distance from the first sub-message, wrapping at 32 bits
            r.sub_time     = parent_time + ({1'b0, raw_time} - {1'b0, time_origin});
            r.sub_stream   = stream_reg;
            r.payload_byte = data;
            r.last_byte    = last;
            return r;
        endfunction

        function void push_error(logic [1:0] code);
            result_t r;
            r            = '0;
            r.kind       = KIND_ERROR;
            r.error_code = code;
            awaited.push_back(r);
            phase = PH_IDLE;
        endfunction

        // one accepted byte: update the parser state, queue any result it causes
        function void take_byte(item_t it);
            logic [23:0] remain;
            logic [3:0]  fld;
            if (it.message_start) begin
                bytes_left  = it.message_length;
                parent_time = it.message_timestamp;
                first_seen  = 1'b0;
                field_count = '0;
                phase       = (it.message_length != 0) ? PH_HEADER : PH_IDLE;
            end
            if (phase == PH_IDLE || bytes_left == 0) begin
                phase = PH_IDLE;
                return;
            end
            bytes_left = bytes_left - 1'b1;
            remain     = bytes_left;
            case (phase)
                PH_HEADER: begin
                    fld = field_count;
                    if (fld == FLD_TYPE) begin
                        type_reg   = it.data_byte;
                        size_reg   = '0;
                        raw_time   = '0;
                        stream_reg = '0;
                    end else if (fld <= FLD_SIZE_LAST) begin
                        size_reg = {size_reg[15:0], it.data_byte};
                    end else if (fld <= FLD_TIME_LAST) begin
                        raw_time = {7'd0, raw_time[15:0], it.data_byte};
                    end else if (fld == FLD_TIME_HIGH) begin
                        // high byte on top, bit 31 dropped
                        raw_time = {it.data_byte[6:0], raw_time[23:0]};
                        if (!first_seen) begin
                            time_origin = raw_time;
                            first_seen  = 1'b1;
                        end
                    end else begin
                        stream_reg = {stream_reg[15:0], it.data_byte};
                    end
                    if (fld < FLD_HEADER_LAST) begin
                        field_count = fld + 1'b1;
                        if (remain == 0)
                            push_error(ERR_TRUNC_HEADER);
                    end else begin
                        field_count = '0;
                        if (size_reg > remain) begin
                            push_error(ERR_SIZE_OVERRUN);
                        end else if (remain - size_reg < TRAILER_MIN) begin
                            push_error(ERR_NO_TRAILER);
                        end else begin
                            forwarding   = (type_reg == TYPE_AUDIO || type_reg == TYPE_VIDEO);
                            payload_left = size_reg;
                            phase        = (size_reg != 0) ? PH_PAYLOAD : PH_TRAILER;
                            if (forwarding)
                                awaited.push_back(header_result(KIND_HEADER, 8'd0, 1'b0));
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (forwarding)
                        awaited.push_back(header_result(KIND_PAYLOAD, it.data_byte,
                                                        payload_left == 1));
                    payload_left = payload_left - 1'b1;
                    if (payload_left == 0) begin
                        phase       = PH_TRAILER;
                        field_count = '0;
                    end
                    if (remain == 0)
                        phase = PH_IDLE;
                end
                default: begin
                    // trailer bytes are skipped unchecked
                    field_count = field_count + 1'b1;
                    if (field_count >= TRAILER_LEN) begin
                        field_count = '0;
                        phase       = PH_HEADER;
                    end
                    if (remain == 0)
                        phase = PH_IDLE;
                end
            endcase
        endfunction

        function string describe(result_t r);
            return $sformatf({"kind %0d type %02h size %06h raw %08h stamp %08h stream %06h",
                              " byte %02h last %0b code %0d"},
                             r.kind, r.sub_type, r.sub_size, r.sub_raw_time, r.sub_time,
                             r.sub_stream, r.payload_byte, r.last_byte, r.error_code);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: %s", describe(got));
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.sub_type !== want.sub_type ||
                got.sub_size !== want.sub_size || got.sub_raw_time !== want.sub_raw_time ||
                got.sub_time !== want.sub_time || got.sub_stream !== want.sub_stream ||
                got.payload_byte !== want.payload_byte || got.last_byte !== want.last_byte ||
                got.error_code !== want.error_code) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rad_msg_if msg ();
    rad_res_if res ();

    rtmp_aggregate_deframer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .res   (res)
    );

    deframe_scoreboard sb;

    int unsigned send_idle_pct = 8;
    int unsigned recv_idle_pct = 55;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;
    int unsigned bytes_sent    = 0;
    logic        long_hold_request;
    result_t     seen;
    logic [7:0]  frame[$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: check each accepted item, then decide ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready) begin
            seen.kind         = res.kind;
            seen.sub_type     = res.sub_type;
            seen.sub_size     = res.sub_size;
            seen.sub_raw_time = res.sub_raw_time;
            seen.sub_time     = res.sub_time;
            seen.sub_stream   = res.sub_stream;
            seen.payload_byte = res.payload_byte;
            seen.last_byte    = res.last_byte;
            seen.error_code   = res.error_code;
            sb.check_result(seen);
        end
        if (!rst_n) begin
            res.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            res.ready <= 1'b0;
        end else if (long_hold_request) begin
            // long stall so the block backs up into its input
            hold_left = LONG_HOLD_CYCLES;
            long_hold_request <= 1'b0;
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            msg.valid <= 1'b0;
            @(posedge clk);
        end
        msg.valid             <= 1'b1;
        msg.data_byte         <= it.data_byte;
        msg.message_start     <= it.message_start;
        msg.message_length    <= it.message_length;
        msg.message_timestamp <= it.message_timestamp;
        @(posedge clk);
        while (!msg.ready)
            @(posedge clk);
        sb.take_byte(it);
    endtask

    // sends the first count bytes of frame as one message
    task automatic send_aggregate(input logic [23:0] length, input logic [31:0] stamp,
                                  input int unsigned count);
        item_t it;
        for (int unsigned i = 0; i < count; i++) begin
            it.data_byte         = frame[i];
            it.message_start     = (i == 0);
            it.message_length    = (i == 0) ? length : 24'($urandom);
            it.message_timestamp = (i == 0) ? stamp : $urandom;
            send_byte(it);
        end
        bytes_sent += count;
    endtask

    // a byte outside any message, or a start with zero length
    task automatic send_loose_byte(input logic zero_start);
        item_t it;
        it.data_byte         = 8'($urandom);
        it.message_start     = zero_start;
        it.message_length    = zero_start ? 24'd0 : 24'($urandom);
        it.message_timestamp = $urandom;
        send_byte(it);
    endtask

    task automatic wait_for_results();
        msg.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic void push_header(logic [7:0] sub_type, logic [23:0] size,
                                        logic [31:0] stamp, logic [23:0] stream);
        frame.push_back(sub_type);
        frame.push_back(size[23:16]);
        frame.push_back(size[15:8]);
        frame.push_back(size[7:0]);
        frame.push_back(stamp[23:16]);
        frame.push_back(stamp[15:8]);
        frame.push_back(stamp[7:0]);
        frame.push_back(stamp[31:24]);
        frame.push_back(stream[23:16]);
        frame.push_back(stream[15:8]);
        frame.push_back(stream[7:0]);
    endfunction

    function automatic void push_noise(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            frame.push_back(8'($urandom));
    endfunction

    // header, payload and trailer of one sub-message
    function automatic void push_sub(logic [7:0] sub_type, logic [23:0] size,
                                     logic [31:0] stamp, logic [23:0] stream);
        push_header(sub_type, size, stamp, stream);
        push_noise(32'(size) + 32'(TRAILER_LEN));
    endfunction

    // mostly well-formed aggregates, some cut short, padded, abandoned or garbage
    task automatic random_aggregate();
        int unsigned pick;
        int unsigned count;
        logic [23:0] length;
        logic [31:0] stamp0;
        logic [7:0]  sub_type;
        logic [23:0] size;
        frame.delete();
        pick = $urandom_range(99);
        if (pick < 6) begin
            send_loose_byte(1'($urandom_range(1)));
            return;
        end
        if (pick < 12) begin
            push_noise($urandom_range(1, 30));
            send_aggregate(24'(frame.size()), $urandom, frame.size());
            return;
        end
        stamp0 = $urandom;
        repeat ($urandom_range(1, 4)) begin
            pick = $urandom_range(99);
            sub_type = (pick < 40) ? TYPE_AUDIO : (pick < 80) ? TYPE_VIDEO : 8'($urandom);
            size = 24'(($urandom_range(99) < 85) ? $urandom_range(0, 12)
                                                 : $urandom_range(13, 64));
            push_sub(sub_type, size,
                     $urandom_range(1) ? stamp0 + $urandom_range(0, 5000) : $urandom,
                     24'($urandom));
        end
        count  = frame.size();
        length = 24'(count);
        pick   = $urandom_range(99);
        if (pick < 10) begin
            // message ends early: truncated header, overrun or missing trailer
            count  = $urandom_range(1, frame.size() - 1);
            length = 24'(count);
        end else if (pick < 18) begin
            // stray bytes after the last sub-message
            push_noise($urandom_range(1, 20));
            count  = frame.size();
            length = 24'(count);
        end else if (pick < 26) begin
            // long declared length, abandoned by the next start
            count  = $urandom_range(1, frame.size());
            length = 24'(count + 1 + $urandom_range(0, 24'hFFFFFF - count - 1));
        end
        send_aggregate(length, $urandom, count);
    endtask

    initial
    begin
        sb = new();
        rst_n                 = 1'b0;
        long_hold_request     = 1'b0;
        msg.valid             = 1'b0;
        msg.data_byte         = '0;
        msg.message_start     = 1'b0;
        msg.message_length    = '0;
        msg.message_timestamp = '0;
        res.ready             = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte while idle, then a zero length start
        send_loose_byte(1'b0);
        send_loose_byte(1'b1);

        // audio with extreme header fields, zero size video, a skipped type, audio again
        frame.delete();
        push_sub(TYPE_AUDIO, 24'd3, 32'hFFFF_FFFF, 24'hFF_FFFF);
        push_sub(TYPE_VIDEO, 24'd0, 32'h0000_0000, 24'h00_0000);
        push_sub(8'd18, 24'd2, 32'h0000_1000, 24'h00_0001);
        push_sub(TYPE_AUDIO, 24'd1, 32'h8000_1234, 24'h12_3456);
        send_aggregate(24'(frame.size()), 32'hFFFF_FFFF, frame.size());

        // first sub-message not forwarded still sets the time base
        frame.delete();
        push_sub(8'd0, 24'd1, 32'h0000_0100, 24'h00_0002);
        push_sub(TYPE_VIDEO, 24'd2, 32'h0000_0050, 24'h00_0003);
        send_aggregate(24'(frame.size()), 32'h0000_0000, frame.size());

        // truncated header
        frame.delete();
        push_header(TYPE_AUDIO, 24'd5, $urandom, 24'($urandom));
        send_aggregate(24'd6, $urandom, 6);

        // size overrun with the widest size
        frame.delete();
        push_header(TYPE_AUDIO, 24'hFF_FFFF, $urandom, 24'($urandom));
        push_noise(10);
        send_aggregate(24'(frame.size()), $urandom, frame.size());

        // missing trailer: two bytes after the payload
        frame.delete();
        push_header(TYPE_VIDEO, 24'd5, $urandom, 24'($urandom));
        push_noise(7);
        send_aggregate(24'(frame.size()), $urandom, frame.size());

        // start while busy: the next message cuts this one off mid payload
        frame.delete();
        push_sub(TYPE_AUDIO, 24'd4, $urandom, 24'($urandom));
        push_header(TYPE_VIDEO, 24'd10, $urandom, 24'($urandom));
        push_noise(3);
        send_aggregate(24'hFF_FFFF, $urandom, frame.size());

        // long payload under a long result stall, input backs up
        long_hold_request <= 1'b1;
        frame.delete();
        push_sub(TYPE_AUDIO, 24'd40, $urandom, 24'($urandom));
        send_aggregate(24'(frame.size()), 32'h8000_0000, frame.size());

        // sender pause until everything is out
        wait_for_results();

        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 8 : (p == 1) ? 55 : 0;
            recv_idle_pct <= (p == 0) ? 55 : (p == 1) ? 8 : 0;
            count_target(p);
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.awaited.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    task automatic count_target(input int p);
        int unsigned target;
        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target)
            random_aggregate();
    endtask

endmodule

// File: rtmp_aggregate_deframer.f
rtl/core/rad_pkg.sv
rtl/core/rad_msg_if.sv
rtl/core/rad_res_if.sv
rtl/core/rad_parser.sv
rtl/core/rtmp_aggregate_deframer.sv
test/tb_top.sv
